/* sv/gf256_arith_unit_defines.svh */
// Assertion macros used by the checker file of the GF(2^8) arithmetic unit.
// Depends on nothing; include by bare file name.
`ifndef GF256_ARITH_UNIT_DEFINES_SVH
`define GF256_ARITH_UNIT_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define GFA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gf256 arithmetic unit check failed");

// Concurrent assertion that is also checked across reset.
`define GFA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gf256 arithmetic unit reset check failed");

`endif

/* sv/gfa_pkg.sv */
// Package for the GF(2^8) arithmetic unit: operation codes, the word type
// that travels along the cell chain, and the field arithmetic functions.
// Depends on nothing.
package gfa_pkg;

  localparam int GF_W    = 8;
  localparam int OP_W    = 2;
  localparam int N_CELLS = 7;

  localparam logic [OP_W-1:0] OP_MUL = 2'd0;
  localparam logic [OP_W-1:0] OP_SQR = 2'd1;
  localparam logic [OP_W-1:0] OP_INV = 2'd2;

  localparam logic [GF_W-1:0] GF_ONE = 8'h01;

  // One word as it moves from cell to cell.
  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] op;
    logic [GF_W-1:0] a;
    logic [GF_W-1:0] b;
    logic [GF_W-1:0] acc;
  } gfa_word_t;

  // Reduce a 15-bit carry-less product modulo x^8+x^4+x^3+x^2+1 in two folds.
  function automatic logic [GF_W-1:0] gf_fold(input logic [14:0] v);
    logic [6:0]  hi1;
    logic [10:0] r1;
    logic [2:0]  hi2;
    logic [7:0]  r2;
    hi1 = v[14:8];
    r1  = {3'b0, v[7:0]} ^ {4'b0, hi1} ^ {2'b0, hi1, 2'b0} ^ {1'b0, hi1, 3'b0}
          ^ {hi1, 4'b0};
    hi2 = r1[10:8];
    r2  = r1[7:0] ^ {5'b0, hi2} ^ {3'b0, hi2, 2'b0} ^ {2'b0, hi2, 3'b0}
          ^ {1'b0, hi2, 4'b0};
    return r2;
  endfunction

  // Field multiply: carry-less product of independent partial products, then fold.
  function automatic logic [GF_W-1:0] gf_mul(input logic [GF_W-1:0] x,
                                             input logic [GF_W-1:0] y);
    logic [14:0] prod;
    prod = '0;
    for (int i = 0; i < GF_W; i++) begin
      if (y[i]) begin
        prod = prod ^ ({7'b0, x} << i);
      end
    end
    return gf_fold(prod);
  endfunction

  // Field square: bit i moves to bit 2i, then fold.
  function automatic logic [GF_W-1:0] gf_sq(input logic [GF_W-1:0] x);
    logic [14:0] spread;
    spread = '0;
    for (int i = 0; i < GF_W; i++) begin
      spread[2*i] = x[i];
    end
    return gf_fold(spread);
  endfunction

endpackage

/* sv/gfa_cell.sv */
// One cell of the GF(2^8) chain: registers one word and applies one step.
// Depends on gfa_pkg.
module gfa_cell #(
  parameter bit IS_FIRST = 1'b0,
  parameter bit IS_LAST  = 1'b0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  gfa_pkg::gfa_word_t w_in,
  output gfa_pkg::gfa_word_t w_out
);
  import gfa_pkg::*;

  gfa_word_t              word;
  logic      [GF_W-1:0]   acc_next;

  // Inverse runs acc <- acc^2 * a in every cell but the last, which only
  // squares; multiply and square finish in the first cell and then ride along.
  always_comb begin
    unique case (w_in.op)
      OP_MUL: acc_next = IS_FIRST ? gf_mul(w_in.acc, w_in.b) : w_in.acc;
      OP_SQR: acc_next = IS_FIRST ? gf_sq(w_in.acc) : w_in.acc;
      OP_INV: acc_next = gf_mul(gf_sq(w_in.acc), IS_LAST ? GF_ONE : w_in.a);
      default: acc_next = '0;
    endcase
  end

  // The valid flag is cleared by reset; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      word.valid <= 1'b0;
    end else if (adv) begin
      word.valid <= w_in.valid;
      word.op    <= w_in.op;
      word.a     <= w_in.a;
      word.b     <= w_in.b;
      word.acc   <= acc_next;
    end
  end

  assign w_out = word;

endmodule

/* sv/gf256_arith_unit.sv */
// Top level of the GF(2^8) arithmetic unit (multiply, square, inverse).
// Depends on gfa_pkg and gfa_cell.
//
// The unit takes one word per cycle while the chain is not held and returns one
// result word for each, in order, once the word has passed all seven cells.
// Each cell holds one word and applies at most one field step (an inverse is
// a^254, built as six square-and-multiply steps and a final square). The whole
// chain moves together: while a finished result waits at the output, the chain
// holds and s_axis_tready is low; otherwise a new word is taken every cycle.
// The field polynomial is x^8+x^4+x^3+x^2+1, the inverse of zero is zero, and
// an unused operation code gives zero.
module gf256_arith_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] operand_a, [15:8] operand_b
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [7:0] product
);
  import gfa_pkg::*;

  gfa_word_t chain [N_CELLS+1];
  logic      adv;

  // The chain advances unless the output word is held by the consumer.
  assign adv = !chain[N_CELLS].valid || m_axis_tready;

  // Entry word: the accumulator starts at operand a.
  always_comb begin
    chain[0].valid = s_axis_tvalid;
    chain[0].op    = s_axis_tuser;
    chain[0].a     = s_axis_tdata[7:0];
    chain[0].b     = s_axis_tdata[15:8];
    chain[0].acc   = s_axis_tdata[7:0];
  end

  // Row of cells; the first and the last are set apart by their parameters.
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    gfa_cell #(
      .IS_FIRST(i == 0),
      .IS_LAST (i == N_CELLS - 1)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .w_in (chain[i]),
      .w_out(chain[i+1])
    );
  end

  assign s_axis_tready = adv;
  assign m_axis_tvalid = chain[N_CELLS].valid;
  assign m_axis_tdata  = chain[N_CELLS].acc;

endmodule

/* sv/gfa_checker.sv */
// Port-level checks for the GF(2^8) arithmetic unit, bound to its top level.
// Depends on gf256_arith_unit_defines.svh and gf256_arith_unit.
`include "gf256_arith_unit_defines.svh"

module gfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // No result word is shown in the cycle after reset.
  `GFA_ASSERT_ALWAYS(a_empty_after_rst, clk, $past(rst) |-> !m_axis_tvalid)

  // With the output empty the chain is free and must be ready to take a word.
  `GFA_ASSERT(a_ready_when_empty, clk, rst, !m_axis_tvalid |-> s_axis_tready)

  // A held result stalls the whole chain, so no input word is taken.
  `GFA_ASSERT(a_stall_blocks_in, clk, rst,
              (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)

  // A stalled result word stays valid and unchanged.
  `GFA_ASSERT(a_out_hold, clk, rst,
              (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

  // An input word that waits for the unit is held steady by the sender.
  `GFA_ASSERT(a_in_hold, clk, rst,
              (s_axis_tvalid && !s_axis_tready) |=>
              (s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser)))

endmodule

bind gf256_arith_unit gfa_checker u_gfa_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

/* dv/tb_top.sv */
// Self-checking testbench for gf256_arith_unit: random and directed field operations
// with a local GF(2^8) predictor, under random stalls on both stream ports.
// Depends on gfa_pkg and the gf256_arith_unit RTL.
module tb_top;
  import gfa_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int N_RANDOM    = 600;
  localparam int DRAIN_WAIT  = 16;
  localparam int CYCLE_LIMIT = 200000;

  // Stimulus phases select the idle pattern of sender and receiver.
  localparam int PH_TX_LIGHT = 0;
  localparam int PH_RX_LIGHT = 1;
  localparam int PH_NO_IDLE  = 2;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [GF_W-1:0] a;
    logic [GF_W-1:0] b;
    bit              drain;
    int              phase;
  } gf_req_t;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [GF_W-1:0] a;
    logic [GF_W-1:0] b;
    logic [GF_W-1:0] product;
  } gf_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] operand_a, [15:8] operand_b
  logic [1:0]  s_axis_tuser = '0;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // [7:0] product

  gf_req_t    req_fifo[$];
  gf_result_t product_q[$];
  int         cur_phase = PH_TX_LIGHT;
  int         n_errors = 0;
  int         n_checked = 0;
  int         n_cycles = 0;
  int         op_count[4] = '{0, 0, 0, 0};

  gf256_arith_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Multiply by x modulo x^8+x^4+x^3+x^2+1.
  function automatic logic [GF_W-1:0] gf_xtime(input logic [GF_W-1:0] v);
    return v[7] ? ({v[6:0], 1'b0} ^ 8'h1d) : {v[6:0], 1'b0};
  endfunction

  // Shift-and-add field multiply, one bit of y per step.
  function automatic logic [GF_W-1:0] field_mul(input logic [GF_W-1:0] x,
                                                input logic [GF_W-1:0] y);
    logic [GF_W-1:0] acc;
    logic [GF_W-1:0] term;
    acc  = '0;
    term = x;
    for (int i = 0; i < GF_W; i++) begin
      if (y[i]) begin
        acc = acc ^ term;
      end
      term = gf_xtime(term);
    end
    return acc;
  endfunction

  // x^254 by binary exponentiation; zero stays zero.
  function automatic logic [GF_W-1:0] field_pow254(input logic [GF_W-1:0] x);
    logic [GF_W-1:0] acc;
    logic [GF_W-1:0] base;
    int              e;
    acc  = GF_ONE;
    base = x;
    e    = 254;
    while (e != 0) begin
      if (e[0]) begin
        acc = field_mul(acc, base);
      end
      base = field_mul(base, base);
      e    = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [GF_W-1:0] expected_product(input logic [OP_W-1:0] op,
                                                       input logic [GF_W-1:0] a,
                                                       input logic [GF_W-1:0] b);
    case (op)
      OP_MUL:  return field_mul(a, b);
      OP_SQR:  return field_mul(a, a);
      OP_INV:  return field_pow254(a);
      default: return '0;
    endcase
  endfunction

  // Operand biased toward the corner values of the field.
  function automatic logic [GF_W-1:0] pick_elem();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return GF_ONE;
      3:       return 8'h80;
      default: return GF_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 45) return OP_MUL;
    if (r < 65) return OP_SQR;
    if (r < 90) return OP_INV;
    return OP_UNUSED;
  endfunction

  function automatic int tx_idle_pct(input int ph);
    return (ph == PH_TX_LIGHT) ? 10 : (ph == PH_RX_LIGHT) ? 57 : 0;
  endfunction

  function automatic int rx_idle_pct(input int ph);
    return (ph == PH_TX_LIGHT) ? 57 : (ph == PH_RX_LIGHT) ? 10 : 0;
  endfunction

  task automatic add_req(input logic [OP_W-1:0] op, input logic [GF_W-1:0] a,
                         input logic [GF_W-1:0] b, input bit drain, input int ph);
    gf_req_t r;
    r.op    = op;
    r.a     = a;
    r.b     = b;
    r.drain = drain;
    r.phase = ph;
    req_fifo.push_back(r);
  endtask

  // Driver: record accepted words, then present the next one or idle.
  always @(posedge clk) begin
    gf_result_t exp_r;
    gf_req_t    nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        exp_r.op      = s_axis_tuser;
        exp_r.a       = s_axis_tdata[7:0];
        exp_r.b       = s_axis_tdata[15:8];
        exp_r.product = expected_product(exp_r.op, exp_r.a, exp_r.b);
        product_q.push_back(exp_r);
        op_count[exp_r.op]++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_fifo.size() == 0 || (req_fifo[0].drain && product_q.size() != 0) ||
            $urandom_range(99) < tx_idle_pct(req_fifo[0].phase)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          nxt = req_fifo.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {nxt.b, nxt.a};
          s_axis_tuser  <= nxt.op;
          cur_phase     <= nxt.phase;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction.
  always @(posedge clk) begin
    gf_result_t exp_r;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (product_q.size() == 0) begin
          $error("unexpected result word: product actual %02h", m_axis_tdata);
          n_errors++;
        end else begin
          exp_r = product_q.pop_front();
          n_checked++;
          if (m_axis_tdata !== exp_r.product) begin
            $error("product mismatch (op %0d a %02h b %02h): expected %02h actual %02h",
                   exp_r.op, exp_r.a, exp_r.b, exp_r.product, m_axis_tdata);
            n_errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct(cur_phase));
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("gf256_arith_unit regression: fail");
      $finish;
    end
  end

  // Build the stimulus, release reset and wait for the last result.
  initial begin
    int ph;
    // Directed corners: extremes, every operation, zero inverse, unused code.
    add_req(OP_MUL, 8'h00, 8'h00, 1'b0, PH_NO_IDLE);
    add_req(OP_MUL, 8'hff, 8'hff, 1'b0, PH_NO_IDLE);
    add_req(OP_MUL, GF_ONE, 8'ha5, 1'b0, PH_NO_IDLE);
    add_req(OP_MUL, 8'h5a, GF_ONE, 1'b0, PH_NO_IDLE);
    add_req(OP_MUL, 8'h80, 8'h80, 1'b0, PH_NO_IDLE);
    add_req(OP_MUL, 8'h00, 8'hff, 1'b0, PH_NO_IDLE);
    add_req(OP_MUL, 8'h02, 8'h8e, 1'b0, PH_NO_IDLE);
    add_req(OP_SQR, 8'h00, 8'hff, 1'b0, PH_NO_IDLE);
    add_req(OP_SQR, GF_ONE, 8'h00, 1'b0, PH_NO_IDLE);
    add_req(OP_SQR, 8'hff, 8'h5a, 1'b0, PH_NO_IDLE);
    add_req(OP_SQR, 8'h80, 8'hff, 1'b0, PH_NO_IDLE);
    add_req(OP_INV, 8'h00, 8'h00, 1'b0, PH_NO_IDLE);
    add_req(OP_INV, 8'h00, 8'hff, 1'b0, PH_NO_IDLE);
    add_req(OP_INV, GF_ONE, 8'h00, 1'b0, PH_NO_IDLE);
    add_req(OP_INV, 8'h02, 8'h33, 1'b0, PH_NO_IDLE);
    add_req(OP_INV, 8'hff, 8'hff, 1'b0, PH_NO_IDLE);
    add_req(OP_INV, 8'h80, 8'ha5, 1'b0, PH_NO_IDLE);
    add_req(OP_UNUSED, 8'h00, 8'h00, 1'b0, PH_NO_IDLE);
    add_req(OP_UNUSED, 8'hff, 8'hff, 1'b0, PH_NO_IDLE);
    add_req(OP_UNUSED, 8'h3c, 8'hc3, 1'b0, PH_NO_IDLE);

    // Random part in three idle phases; each phase starts on an empty pipeline.
    for (int i = 0; i < N_RANDOM; i++) begin
      ph = (i < N_RANDOM / 3) ? PH_TX_LIGHT :
           (i < 2 * N_RANDOM / 3) ? PH_RX_LIGHT : PH_NO_IDLE;
      add_req(pick_op(), pick_elem(), pick_elem(),
              (i == 0 || i == N_RANDOM / 3 || i == 2 * N_RANDOM / 3), ph);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (req_fifo.size() != 0 || s_axis_tvalid || product_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Checked %0d result words: %0d multiply, %0d square, %0d inverse, %0d unused op.",
             n_checked, op_count[OP_MUL], op_count[OP_SQR], op_count[OP_INV],
             op_count[OP_UNUSED]);
    $display("Idle patterns covered: sender-light, receiver-light and full rate.");
    if (n_errors == 0) begin
      $display("gf256_arith_unit regression: pass");
    end else begin
      $display("gf256_arith_unit regression: fail");
    end
    $finish;
  end

endmodule
